FILE: rtl/kmer_histogram_counter_top_macros.svh
// assertion macros for the k-mer histogram counter
`ifndef KMER_HISTOGRAM_COUNTER_TOP_MACROS_SVH
`define KMER_HISTOGRAM_COUNTER_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define KHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("khc assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define KHC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("khc assertion failed");

`endif

FILE: rtl/khc_pkg.sv
// package: request/response payloads, modes, control structs, base decode
`default_nettype none

package khc_pkg;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned INDEX_W = 16;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_CHAR  = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_T = 2'd1;
    localparam logic [1:0] CODE_C = 2'd2;
    localparam logic [1:0] CODE_G = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         base_char;
        logic [INDEX_W-1:0] read_index;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [INDEX_W-1:0] index_echo;
    } t_out_rsp;

    // controller to datapath
    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic char_en;
        logic rd_char;
        logic rd_read;
        logic wr_back;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_letter;
        logic count_now;
        logic out_free;
    } t_sts;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic [1:0] base_code(input logic [7:0] c);
        logic [1:0] code;
        code = CODE_A;
        if (c == CHAR_T) code = CODE_T;
        else if (c == CHAR_C) code = CODE_C;
        else if (c == CHAR_G) code = CODE_G;
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kmer_histogram_counter_top.sv
// Counts K-base substrings of a character stream in a 32-bit saturating table of
// TABLE_DEPTH counts (TABLE_DEPTH a power of two; the window index is taken modulo
// it). Letters shift a 2-bit code into the window (T=1, C=2, G=3, others 0),
// non-letters and mode 3 are dropped. A letter that does not yet complete K
// letters only shifts the window; one that does also reads the count memory,
// then writes back the incremented count. A count read reads the memory, then
// loads the response once the previous response has left the output register.
// A clear request zeroes one memory word per cycle; after reset the same sweep
// runs with the input stalled. One request is in flight at a time.
`default_nettype none
`include "kmer_histogram_counter_top_macros.svh"

module kmer_histogram_counter_top import khc_pkg::*; #(
    parameter int unsigned KMER_LEN    = 8,
    parameter int unsigned TABLE_DEPTH = 65536
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_rsp     o_out_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    khc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_req.mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    khc_datapath #(
        .KMER_LEN    (KMER_LEN),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // a counted letter always writes back in the following cycle
    `KHC_ASSERT_NXT(a_rd_then_wb, w_cmd.rd_char, w_cmd.wr_back)
    // the sweep and the write-back never share the memory write port
    `KHC_ASSERT_IMP(a_wb_no_clr, w_cmd.wr_back, !w_cmd.clr_step)
    // no request is taken while the table is being zeroed
    `KHC_ASSERT_IMP(a_clr_stalls, w_cmd.clr_step, o_in_stall)
    // a response is never loaded over one that is still held
    `KHC_ASSERT_IMP(a_load_free, w_cmd.out_load, !o_out_valid || !i_out_stall)

endmodule

`default_nettype wire

FILE: rtl/khc_ctrl.sv
// controller: sequences clear sweeps, count updates and count reads
`default_nettype none

module khc_ctrl import khc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_mode,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_UPD   = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                        MODE_CHAR: begin
                            if (i_sts.is_letter) begin
                                o_cmd.char_en = 1'b1;
                                if (i_sts.count_now) begin
                                    o_cmd.rd_char = 1'b1;
                                    n_state = S_UPD;
                                end
                            end
                        end
                        MODE_READ: begin
                            o_cmd.rd_read = 1'b1;
                            n_state = S_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            S_UPD: begin
                o_cmd.wr_back = 1'b1;
                n_state = S_IDLE;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/khc_datapath.sv
// datapath: rolling window, count memory, saturating increment, response register
`default_nettype none

module khc_datapath import khc_pkg::*; #(
    parameter int unsigned KMER_LEN    = 8,
    parameter int unsigned TABLE_DEPTH = 65536
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in_req i_in_req,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_out_stall,
    output t_sts         o_sts,
    output logic         o_out_valid,
    output t_out_rsp     o_out_rsp
);

    localparam int unsigned WIN_W  = 2 * KMER_LEN;
    localparam int unsigned LET_W  = $clog2(KMER_LEN + 1);
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned SLOT_W = (WIN_W > ADDR_W) ? WIN_W : ADDR_W;
    localparam int unsigned RIDX_W = (INDEX_W > ADDR_W) ? INDEX_W : ADDR_W;
    localparam int unsigned CMP_W  = RIDX_W + 1;

    logic [WIN_W-1:0]   r_window;
    logic [LET_W-1:0]   r_letters;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_slot;
    logic [INDEX_W-1:0] r_ridx;
    logic               r_in_range;
    logic [COUNT_W-1:0] r_rdata;
    logic               r_out_valid;
    t_out_rsp           r_out;
    logic [COUNT_W-1:0] r_mem [TABLE_DEPTH];

    logic [WIN_W-1:0]   n_window;
    logic [LET_W-1:0]   n_letters;
    logic [SLOT_W-1:0]  slot_ext;
    logic [ADDR_W-1:0]  n_slot;
    logic [RIDX_W-1:0]  ridx_ext;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] inc_count;

    // shift the new base in at the low end, oldest base falls off the top
    assign n_window  = WIN_W'({r_window, base_code(i_in_req.base_char)});
    assign n_letters = (r_letters == LET_W'(KMER_LEN)) ? r_letters : r_letters + 1'b1;

    // table depth is a power of two, so the modulo keeps the low address bits
    assign slot_ext = SLOT_W'(n_window);
    assign n_slot   = slot_ext[ADDR_W-1:0];
    assign ridx_ext = RIDX_W'(i_in_req.read_index);

    assign rd_en   = i_cmd.rd_char | i_cmd.rd_read;
    assign rd_addr = i_cmd.rd_char ? n_slot : ridx_ext[ADDR_W-1:0];

    assign inc_count = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
    assign wr_en     = i_cmd.clr_step | i_cmd.wr_back;
    assign wr_addr   = i_cmd.clr_step ? r_clr_addr : r_slot;
    assign wr_data   = i_cmd.clr_step ? '0 : inc_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_letters  <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_window   <= '0;
                r_letters  <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.char_en) begin
                    r_window  <= n_window;
                    r_letters <= n_letters;
                end
                if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_char) r_slot <= n_slot;
        if (i_cmd.rd_read) begin
            r_ridx     <= i_in_req.read_index;
            r_in_range <= (CMP_W'(i_in_req.read_index) < CMP_W'(TABLE_DEPTH));
        end
    end

    // response register, refilled in the cycle the old response leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.count_value <= r_in_range ? r_rdata : '0;
            r_out.index_echo  <= r_ridx;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1));
    assign o_sts.is_letter = is_letter(i_in_req.base_char);
    assign o_sts.count_now = (n_letters == LET_W'(KMER_LEN));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

`default_nettype wire
